// ----- hdl/boxblur_pkg.sv -----
// Shared types and constants of the 3x3 box blur block.
// Request structs, opcodes, register indexes and divider constants.
// Depends on nothing; compile before every other file.
package boxblur_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;

    // Nine bytes sum to at most 2295, which fits in twelve bits.
    localparam int SUM_W = 12;

    // floor(s / 9) equals (s * 7282) >> 16 for every s below 4915.
    localparam int                 RECIP_W  = 13;
    localparam logic [RECIP_W-1:0] RECIP9   = 13'd7282;
    localparam int                 RECIP_SH = 16;

    localparam logic [CH_W-1:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic            opcode;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        logic            frame_end;
    } t_out_req;

endpackage

// ----- hdl/box_blur_3x3_rgb.sv -----
// Top level of the 3x3 box blur: line store memory, window and output pipeline.
// Depends on boxblur_pkg for the request structs and constants.
//
// Usage. Pixels enter on the input channel in raster order, one request per
// pixel, with opcode set to pixel. Each accepted request may cause one output
// request: the blurred pixel whose position lies image_width+1 pixels behind
// the newest input. Positions on the first and last row and column come out as
// zero in all four channels; inside pixels carry alpha 255. Once the whole
// frame has been received, drain requests (or surplus pixels, which are
// discarded) push out the remaining border positions, and the last output of
// the frame carries frame_end. The counters then start the next frame.
// Throughput is one request per clock while the receiver keeps up; the line
// stores are one dual-row memory read at the column of the incoming pixel and
// written back as each pixel leaves stage one, so they sustain that rate. An
// output moves through stage one (read), stage two (sum), output register (divide).
// When the receiver stalls, the pipeline keeps taking requests until its
// three stages are occupied, then lowers o_in_ready. Reset restores the
// default 640x480 geometry and an empty pipeline; the line store contents
// are left as they are and need no clearing. A configuration write restarts
// the frame and should only be issued while the block is idle.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = boxblur_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = boxblur_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  boxblur_pkg::t_in_req            i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output boxblur_pkg::t_out_req           o_out_data,
    input  logic                            i_cfg_we,
    input  logic [boxblur_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [boxblur_pkg::CFG_W-1:0]   i_cfg_data
);
    import boxblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = $clog2(MAX_WIDTH + 3);
    localparam int ENT_W = 2 * PIX_W;
    localparam int PRD_W = SUM_W + RECIP_W;

    typedef struct packed {
        logic             take_px;
        logic             emit;
        logic             interior;
        logic             last;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] px;
    } t_s1;

    // ---------------------------------------------------------------------
    // Configuration registers and the clamped frame geometry.
    // ---------------------------------------------------------------------
    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic             cfg_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RESET;
            r_img_h <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) begin
                r_img_w <= i_cfg_data;
            end
            if (i_cfg_idx == REG_HEIGHT) begin
                r_img_h <= i_cfg_data;
            end
        end
    end

    assign cfg_restart = i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT));

    always_comb begin
        if (r_img_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_img_h);
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake. Stage one does the window update for every taken
    // pixel; stage two and the output register only see emitting requests.
    // ---------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    t_s1  r_s1;
    logic out_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic in_acc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_go      = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_go      = r_s1_valid && (!r_s1.emit || s2_free);
    assign s1_free    = !r_s1_valid || s1_go;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && s1_free;

    // ---------------------------------------------------------------------
    // Front end: position counters. The lag counts pixels received but not
    // yet matched by an output; an output is due once it reaches width+2,
    // or at any time after the whole frame is in.
    // ---------------------------------------------------------------------
    logic [WW-1:0] r_in_col;
    logic [HW-1:0] r_in_row;
    logic [WW-1:0] r_out_col;
    logic [HW-1:0] r_out_row;
    logic [LW-1:0] r_lag;

    logic [WW-1:0] n_in_col;
    logic [HW-1:0] n_in_row;
    logic [WW-1:0] n_out_col;
    logic [HW-1:0] n_out_row;
    logic [LW-1:0] n_lag;
    logic [WW-1:0] in_col_p1;
    logic [WW-1:0] out_col_p1;
    logic [HW-1:0] out_row_p1;
    logic [LW-1:0] lag_px;
    logic          take_px;
    logic          emit;
    logic          interior;
    logic          last;

    always_comb begin
        in_col_p1  = r_in_col + WW'(1);
        out_col_p1 = r_out_col + WW'(1);
        out_row_p1 = r_out_row + HW'(1);
        take_px    = (i_in_data.opcode == OP_PIXEL) && (r_in_row < eff_h);

        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (take_px) begin
            if (in_col_p1 == eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + HW'(1);
            end else begin
                n_in_col = in_col_p1;
            end
        end

        lag_px = r_lag + {{(LW-1){1'b0}}, take_px};
        emit   = (n_in_row == eff_h) || (lag_px >= (LW'(eff_w) + LW'(2)));

        interior = (r_out_row != '0) && (out_row_p1 < eff_h) &&
                   (r_out_col != '0) && (out_col_p1 < eff_w);
        last     = (out_row_p1 == eff_h) && (out_col_p1 == eff_w);

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lag     = lag_px;
        if (emit) begin
            n_lag = lag_px - LW'(1);
            if (last) begin
                // End of frame: every counter returns to the frame origin.
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_lag     = '0;
            end else if (out_col_p1 == eff_w) begin
                n_out_col = '0;
                n_out_row = out_row_p1;
            end else begin
                n_out_col = out_col_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lag     <= '0;
        end else if (in_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lag     <= n_lag;
        end
    end

    // ---------------------------------------------------------------------
    // Line store memory. Each entry holds the two previous rows at one
    // column as {older, prior}. It is read when a request is accepted and
    // written back when a taken pixel leaves stage one. A read of the entry
    // being written in the same cycle takes the new data from a bypass.
    // ---------------------------------------------------------------------
    logic [ENT_W-1:0] mem [MAX_WIDTH];
    logic [ENT_W-1:0] r_rd;
    logic             r_fwd;
    logic [ENT_W-1:0] r_fwd_data;
    logic [COL_W-1:0] rd_addr;
    logic [ENT_W-1:0] s1_rd;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;

    assign rd_addr = r_in_col[COL_W-1:0];
    assign s1_rd   = r_fwd ? r_fwd_data : r_rd;
    assign wr_data = {s1_rd[PIX_W-1:0], r_s1.px};
    assign wr_en   = s1_go && r_s1.take_px;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1.col] <= wr_data;
        end
        if (in_acc) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= wr_en && (r_s1.col == rd_addr);
        end
        if (in_acc) begin
            r_fwd_data <= wr_data;
        end
    end

    // Stage one register: decisions made at acceptance travel with the pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1.take_px  <= take_px;
            r_s1.emit     <= emit;
            r_s1.interior <= interior;
            r_s1.last     <= last;
            r_s1.col      <= rd_addr;
            r_s1.px       <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        end
    end

    // ---------------------------------------------------------------------
    // Neighbour window: row 0 oldest, column 2 newest. The sums are taken
    // over the window as it stands after this request's shift.
    // ---------------------------------------------------------------------
    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_r;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = s1_rd[ENT_W-1:PIX_W];
        n_win[1][2] = s1_rd[PIX_W-1:0];
        n_win[2][2] = r_s1.px;
    end

    always_comb begin
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sum_b = sum_b + SUM_W'(n_win[r][c][CH_W-1:0]);
                sum_g = sum_g + SUM_W'(n_win[r][c][2*CH_W-1:CH_W]);
                sum_r = sum_r + SUM_W'(n_win[r][c][3*CH_W-1:2*CH_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (wr_en) begin
            r_win <= n_win;
        end
    end

    // ---------------------------------------------------------------------
    // Stage two: channel sums. The divide by nine is a reciprocal multiply
    // whose product feeds the output register directly.
    // ---------------------------------------------------------------------
    logic [SUM_W-1:0] r_s2_sum_r;
    logic [SUM_W-1:0] r_s2_sum_g;
    logic [SUM_W-1:0] r_s2_sum_b;
    logic             r_s2_interior;
    logic             r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_go && r_s1.emit) begin
            r_s2_valid <= 1'b1;
        end else if (s2_go) begin
            r_s2_valid <= 1'b0;
        end
        if (s1_go && r_s1.emit) begin
            r_s2_sum_r    <= r_s1.take_px ? sum_r : '0;
            r_s2_sum_g    <= r_s1.take_px ? sum_g : '0;
            r_s2_sum_b    <= r_s1.take_px ? sum_b : '0;
            r_s2_interior <= r_s1.interior;
            r_s2_last     <= r_s1.last;
        end
    end

    logic [PRD_W-1:0] prod_r;
    logic [PRD_W-1:0] prod_g;
    logic [PRD_W-1:0] prod_b;

    assign prod_r = PRD_W'(r_s2_sum_r) * PRD_W'(RECIP9);
    assign prod_g = PRD_W'(r_s2_sum_g) * PRD_W'(RECIP9);
    assign prod_b = PRD_W'(r_s2_sum_b) * PRD_W'(RECIP9);

    t_out_req r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s2_go) begin
            if (r_s2_interior) begin
                r_out.red_out   <= prod_r[RECIP_SH+CH_W-1:RECIP_SH];
                r_out.green_out <= prod_g[RECIP_SH+CH_W-1:RECIP_SH];
                r_out.blue_out  <= prod_b[RECIP_SH+CH_W-1:RECIP_SH];
                r_out.alpha_out <= ALPHA_FULL;
            end else begin
                r_out.red_out   <= '0;
                r_out.green_out <= '0;
                r_out.blue_out  <= '0;
                r_out.alpha_out <= '0;
            end
            r_out.frame_end <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_lag_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lag <= (LW'(eff_w) + LW'(1)))
        else $error("input has run more than a row and a pixel ahead of the output");

    a_border_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.alpha_out == '0 && o_out_data.red_out == '0 &&
                          o_out_data.green_out == '0 && o_out_data.blue_out == '0) ||
                         o_out_data.alpha_out == ALPHA_FULL))
        else $error("border output with non-zero colour or odd alpha");

    a_last_is_border : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_end) |-> (o_out_data.alpha_out == '0))
        else $error("frame end flagged on an inside pixel");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stalled stage one request was lost or changed");

endmodule
